// ===== rtl/xmlx_pkg.sv =====
// Shared types and constants for the XML markup lexer.
// Used by every module under rtl; depends on nothing else.
package xmlx_pkg;

    localparam int DEPTH_BITS_DEF = 8;

    localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '\''
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\\'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_QMARK  = 8'h3F;  // '?'
    localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'

    typedef struct packed {
        logic [7:0] char_val;
        logic [3:0] lex_state;
        logic [7:0] nest_depth;
        logic       record_end;
    } result_t;

endpackage

// ===== rtl/xmlx_lex.sv =====
// Lexer state machine: state, quote kind and nesting depth, plus the
// result for the byte on the input. Depends on xmlx_pkg.
module xmlx_lex #(
    parameter int DEPTH_BITS = xmlx_pkg::DEPTH_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        char_in,
    input  logic [7:0]        record_depth,
    output xmlx_pkg::result_t res
);
    import xmlx_pkg::*;

    localparam int CMP_W = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;

    typedef enum logic [3:0] {
        S_TEXT   = 4'd0,
        S_OPEN   = 4'd1,
        S_TAG    = 4'd2,
        S_CLOSE  = 4'd3,
        S_SELF   = 4'd4,
        S_QUOTE  = 4'd5,
        S_QESC   = 4'd6,
        S_PRECOM = 4'd7,
        S_COM    = 4'd8,
        S_COM_M  = 4'd9,
        S_COM_MM = 4'd10,
        S_DECL   = 4'd11,
        S_DECL_Q = 4'd12
    } state_t;

    state_t                state_reg, state_next;
    logic                  quote_reg, quote_next;
    logic [DEPTH_BITS-1:0] nest_reg, nest_next;
    logic                  rec;
    logic [7:0]            quote_char;
    logic [CMP_W-1:0]      nest_ext;
    logic [CMP_W-1:0]      rec_ext;
    logic                  depth_hit;

    assign quote_char = quote_reg ? CH_SQUOTE : CH_DQUOTE;
    assign nest_ext   = CMP_W'(nest_next);
    assign rec_ext    = CMP_W'(record_depth);
    assign depth_hit  = (nest_ext == rec_ext);

    always_comb
    begin
        state_next = state_reg;
        quote_next = quote_reg;
        nest_next  = nest_reg;
        rec        = 1'b0;
        case (state_reg)
            S_TEXT:
            begin
                if (char_in == CH_LT) state_next = S_OPEN;
            end
            S_OPEN:
            begin
                if (char_in == CH_QMARK)      state_next = S_DECL;
                else if (char_in == CH_BANG)  state_next = S_PRECOM;
                else if (char_in == CH_SLASH) state_next = S_CLOSE;
                else                          state_next = S_TAG;
            end
            S_TAG:
            begin
                if (char_in == CH_GT)
                begin
                    state_next = S_TEXT;
                    if (nest_reg != '1) nest_next = nest_reg + DEPTH_BITS'(1);
                end
                else if (char_in == CH_DQUOTE)
                begin
                    state_next = S_QUOTE;
                    quote_next = 1'b0;
                end
                else if (char_in == CH_SQUOTE)
                begin
                    state_next = S_QUOTE;
                    quote_next = 1'b1;
                end
                else if (char_in == CH_SLASH)
                begin
                    state_next = S_SELF;
                end
            end
            S_CLOSE:
            begin
                if (char_in == CH_GT)
                begin
                    // saturate at zero
                    if (nest_reg != '0) nest_next = nest_reg - DEPTH_BITS'(1);
                    rec        = depth_hit;
                    state_next = S_TEXT;
                end
            end
            S_SELF:
            begin
                if (char_in == CH_GT)
                begin
                    rec        = depth_hit;
                    state_next = S_TEXT;
                end
                else
                begin
                    state_next = S_TAG;
                end
            end
            S_PRECOM, S_COM:
            begin
                if (char_in == CH_MINUS) state_next = S_COM_M;
            end
            S_COM_M:  state_next = (char_in == CH_MINUS) ? S_COM_MM : S_COM;
            S_COM_MM: state_next = (char_in == CH_GT) ? S_TEXT : S_COM;
            S_DECL:
            begin
                if (char_in == CH_QMARK) state_next = S_DECL_Q;
            end
            S_DECL_Q: state_next = (char_in == CH_GT) ? S_TEXT : S_DECL;
            S_QUOTE:
            begin
                // backslash wins over the closing quote
                if (char_in == CH_BSLASH)       state_next = S_QESC;
                else if (char_in == quote_char) state_next = S_TAG;
            end
            S_QESC:   state_next = S_QUOTE;
            default:  state_next = S_TEXT;
        endcase
    end

    always_comb
    begin
        res.char_val   = char_in;
        res.lex_state  = state_next;
        res.nest_depth = nest_ext[7:0];
        res.record_end = rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TEXT;
            quote_reg <= 1'b0;
            nest_reg  <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            quote_reg <= quote_next;
            nest_reg  <= nest_next;
        end
    end

endmodule

// ===== rtl/xmlx_result.sv =====
// Result register with valid flag; holds a request until the sink takes it.
// Depends on xmlx_pkg.
module xmlx_result (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  xmlx_pkg::result_t res_in,
    input  logic              result_ready,
    output logic              result_valid,
    output xmlx_pkg::result_t res_out
);
    import xmlx_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign valid_next   = load | (valid_reg & ~result_ready);
    assign result_valid = valid_reg;
    assign res_out      = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load) data_reg <= res_in;
    end

endmodule

// ===== rtl/xml_markup_lexer_step.sv =====
// XML markup lexer, one byte per request.
// The result is registered: it is valid in the cycle after the byte is accepted.
// Throughput: 1 byte per cycle while the sink drains the result; the lexer state update is the only loop.
// A new byte is taken while the result slot is empty or being drained.
// Reset (rst_n low, async): text state, depth 0, record_depth 0, no result.
// Depends on xmlx_pkg, xmlx_lex and xmlx_result.
module xml_markup_lexer_step #(
    parameter int DEPTH_BITS = xmlx_pkg::DEPTH_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] char_in,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] char_out,
    output logic [3:0] lex_state,
    output logic [7:0] nest_depth,
    output logic       record_end
);
    import xmlx_pkg::*;

    logic [7:0] record_depth_reg;
    logic       take;
    result_t    res_now;
    result_t    res_held;

    assign cfg_ready  = 1'b1;
    assign item_ready = ~result_valid | result_ready;
    assign take       = item_valid & item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            record_depth_reg <= '0;
        else if (cfg_valid)
            record_depth_reg <= cfg_data;
    end

    xmlx_lex #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_lex (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .char_in     (char_in),
        .record_depth(record_depth_reg),
        .res         (res_now)
    );

    xmlx_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .res_in      (res_now),
        .result_ready(result_ready),
        .result_valid(result_valid),
        .res_out     (res_held)
    );

    assign char_out   = res_held.char_val;
    assign lex_state  = res_held.lex_state;
    assign nest_depth = res_held.nest_depth;
    assign record_end = res_held.record_end;

endmodule
